// File: rtl/power_up_down_sequencer_core_defines.svh
// Assertion macros shared by the power sequencer checker.
// Self-contained; no other file is needed.
`ifndef POWER_UP_DOWN_SEQUENCER_CORE_DEFINES_SVH
`define POWER_UP_DOWN_SEQUENCER_CORE_DEFINES_SVH

// Clocked property; the check is disabled while the reset is high.
`define PWRSEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen while the reset is low.
`define PWRSEQ_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/pwrseq_pkg.sv
// Shared codes and types of the power sequencer.
// Used by the core and by its port checker; depends on nothing.
`default_nettype none

package pwrseq_pkg;

   // Event codes carried by a request.
   localparam logic [2:0] FUNC_TICK      = 3'd0;
   localparam logic [2:0] FUNC_REQ_ON    = 3'd1;
   localparam logic [2:0] FUNC_REQ_STBY  = 3'd2;
   localparam logic [2:0] FUNC_TOGGLE    = 3'd3;
   localparam logic [2:0] FUNC_HOST_UP   = 3'd4;

   // Power mode codes as reported on the result channel.
   localparam logic [1:0] PMODE_STANDBY  = 2'd0;
   localparam logic [1:0] PMODE_STARTING = 2'd1;
   localparam logic [1:0] PMODE_ON       = 2'd2;
   localparam logic [1:0] PMODE_STOPPING = 2'd3;

   // Control register indexes.
   localparam logic [2:0] CSR_MAINS_TO_SECONDARY = 3'd0;
   localparam logic [2:0] CSR_RAILS_SETTLE       = 3'd1;
   localparam logic [2:0] CSR_UNMUTE_DELAY       = 3'd2;
   localparam logic [2:0] CSR_MUTE_BEFORE_SHDN   = 3'd3;
   localparam logic [2:0] CSR_HALT_TIMEOUT       = 3'd4;
   localparam logic [2:0] CSR_SECONDARY_TO_MAINS = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int MS_W        = 16;

   // Register reset values in milliseconds.
   localparam logic [MS_W-1:0] RST_MAINS_TO_SECONDARY = 16'd500;
   localparam logic [MS_W-1:0] RST_RAILS_SETTLE       = 16'd300;
   localparam logic [MS_W-1:0] RST_UNMUTE_DELAY       = 16'd2500;
   localparam logic [MS_W-1:0] RST_MUTE_BEFORE_SHDN   = 16'd200;
   localparam logic [MS_W-1:0] RST_HALT_TIMEOUT       = 16'd30000;
   localparam logic [MS_W-1:0] RST_SECONDARY_TO_MAINS = 16'd500;

   // Bit positions inside the drive vector.
   localparam int DRV_MUTE      = 0;
   localparam int DRV_MAINS     = 1;
   localparam int DRV_SECONDARY = 2;
   localparam int DRV_LED_POWER = 3;
   localparam int DRV_LED_READY = 4;
   localparam int DRV_SHUTDOWN  = 5;
   localparam int DRV_W         = 6;

   // One result item.
   typedef struct packed {
      logic [1:0] power_mode;
      logic       mains_relay;
      logic       secondary_relay;
      logic       hard_mute;
      logic       led_power;
      logic       led_ready;
      logic       shutdown_request;
      logic       chips_init_pulse;
      logic       meter_stop_pulse;
      logic       announce_pulse;
      logic       save_settings_pulse;
      logic       host_up;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/power_up_down_sequencer_core.sv
// Power sequencer core: mode and step state, millisecond timer, control
// registers, and a result register with a skid stage. Depends on pwrseq_pkg.
// A result is registered into the result register, or into the skid stage while the consumer holds it.
// Throughput: one request per cycle while req_stall is low; the timer compare and step update
// sit between the request port and the result register.
// Reset (synchronous): standby, step 0, timer 0, mute only, host flag
// clear, control registers at their default delays, no result pending.
`default_nettype none

module power_up_down_sequencer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_func,
   input  wire logic                                req_host_halted,
   // Result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_power_mode,
   output logic                                     rsp_mains_relay,
   output logic                                     rsp_secondary_relay,
   output logic                                     rsp_hard_mute,
   output logic                                     rsp_led_power,
   output logic                                     rsp_led_ready,
   output logic                                     rsp_shutdown_request,
   output logic                                     rsp_chips_init_pulse,
   output logic                                     rsp_meter_stop_pulse,
   output logic                                     rsp_announce_pulse,
   output logic                                     rsp_save_settings_pulse,
   output logic                                     rsp_host_up,
   // Control register write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pwrseq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pwrseq_pkg::MS_W-1:0]         csr_wdata
);

   typedef enum logic [1:0] {
      MODE_STANDBY  = pwrseq_pkg::PMODE_STANDBY,
      MODE_STARTING = pwrseq_pkg::PMODE_STARTING,
      MODE_ON       = pwrseq_pkg::PMODE_ON,
      MODE_STOPPING = pwrseq_pkg::PMODE_STOPPING
   } mode_type;

   typedef enum logic [1:0] {
      STEP_ENTRY  = 2'd0,
      STEP_FIRST  = 2'd1,
      STEP_SECOND = 2'd2,
      STEP_LAST   = 2'd3
   } step_type;

   localparam logic [pwrseq_pkg::MS_W-1:0] MS_MAX = '1;

   // Sequencer state
   mode_type                            mode_ff, mode_in;
   step_type                            step_ff, step_in;
   logic [pwrseq_pkg::MS_W-1:0]         elapsed_ff, elapsed_in;
   logic [pwrseq_pkg::DRV_W-1:0]        drive_ff, drive_in;
   logic                                host_up_ff, host_up_in;

   // Control registers
   logic [pwrseq_pkg::MS_W-1:0]         mains_to_sec_ff, rails_settle_ff, unmute_delay_ff;
   logic [pwrseq_pkg::MS_W-1:0]         mute_before_ff, halt_timeout_ff, sec_to_mains_ff;

   // Result register and skid stage
   pwrseq_pkg::result_type              rsp_ff, skid_ff, result_in;
   logic                                rsp_valid_ff, skid_valid_ff;

   logic                                req_accept, rsp_take, csr_write;
   logic [pwrseq_pkg::MS_W-1:0]         elapsed_inc;
   logic                                p_init, p_mstop, p_announce, p_save;

   assign req_accept  = req_valid && !skid_valid_ff;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign elapsed_inc = (elapsed_ff == MS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // Next state for the accepted request.
   always_comb begin
      mode_in    = mode_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      drive_in   = drive_ff;
      host_up_in = host_up_ff;
      p_init     = 1'b0;
      p_mstop    = 1'b0;
      p_announce = 1'b0;
      p_save     = 1'b0;

      unique case (req_func)
         pwrseq_pkg::FUNC_TICK: begin
            elapsed_in = elapsed_inc;
            unique case (mode_ff)
               MODE_STARTING: begin
                  unique case (step_ff)
                     STEP_ENTRY: begin
                        drive_in[pwrseq_pkg::DRV_MUTE]      = 1'b1;
                        drive_in[pwrseq_pkg::DRV_MAINS]     = 1'b1;
                        drive_in[pwrseq_pkg::DRV_LED_POWER] = 1'b1;
                        step_in    = STEP_FIRST;
                        elapsed_in = '0;
                     end
                     STEP_FIRST: begin
                        if (elapsed_inc >= mains_to_sec_ff) begin
                           drive_in[pwrseq_pkg::DRV_SECONDARY] = 1'b1;
                           step_in    = STEP_SECOND;
                           elapsed_in = '0;
                        end
                     end
                     STEP_SECOND: begin
                        if (elapsed_inc >= rails_settle_ff) begin
                           drive_in[pwrseq_pkg::DRV_MUTE] = 1'b1;
                           p_init     = 1'b1;
                           step_in    = STEP_LAST;
                           elapsed_in = '0;
                        end
                     end
                     STEP_LAST: begin
                        if (elapsed_inc >= unmute_delay_ff) begin
                           drive_in[pwrseq_pkg::DRV_MUTE]      = 1'b0;
                           drive_in[pwrseq_pkg::DRV_LED_READY] = 1'b1;
                           mode_in    = MODE_ON;
                           p_announce = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               MODE_STOPPING: begin
                  unique case (step_ff)
                     STEP_ENTRY: begin
                        drive_in[pwrseq_pkg::DRV_MUTE]      = 1'b1;
                        drive_in[pwrseq_pkg::DRV_LED_READY] = 1'b0;
                        step_in    = STEP_FIRST;
                        elapsed_in = '0;
                     end
                     STEP_FIRST: begin
                        if (elapsed_inc >= mute_before_ff) begin
                           drive_in[pwrseq_pkg::DRV_SHUTDOWN] = 1'b1;
                           step_in    = STEP_SECOND;
                           elapsed_in = '0;
                        end
                     end
                     STEP_SECOND: begin
                        if (req_host_halted || (elapsed_inc >= halt_timeout_ff)) begin
                           drive_in[pwrseq_pkg::DRV_SECONDARY] = 1'b0;
                           p_mstop    = 1'b1;
                           step_in    = STEP_LAST;
                           elapsed_in = '0;
                        end
                     end
                     STEP_LAST: begin
                        if (elapsed_inc >= sec_to_mains_ff) begin
                           drive_in[pwrseq_pkg::DRV_MAINS]     = 1'b0;
                           drive_in[pwrseq_pkg::DRV_SHUTDOWN]  = 1'b0;
                           drive_in[pwrseq_pkg::DRV_LED_POWER] = 1'b0;
                           host_up_in = 1'b0;
                           mode_in    = MODE_STANDBY;
                           p_save     = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         pwrseq_pkg::FUNC_REQ_ON: begin
            if (mode_ff == MODE_STANDBY) begin
               mode_in    = MODE_STARTING;
               step_in    = STEP_ENTRY;
               elapsed_in = '0;
            end
         end
         pwrseq_pkg::FUNC_REQ_STBY: begin
            if (mode_ff == MODE_ON) begin
               mode_in    = MODE_STOPPING;
               step_in    = STEP_ENTRY;
               elapsed_in = '0;
            end
         end
         pwrseq_pkg::FUNC_TOGGLE: begin
            // From on a toggle asks for standby; from standby it asks for on; in the other modes it does nothing.
            if (mode_ff == MODE_ON) begin
               mode_in    = MODE_STOPPING;
               step_in    = STEP_ENTRY;
               elapsed_in = '0;
            end else if (mode_ff == MODE_STANDBY) begin
               mode_in    = MODE_STARTING;
               step_in    = STEP_ENTRY;
               elapsed_in = '0;
            end
         end
         pwrseq_pkg::FUNC_HOST_UP: begin
            host_up_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Result fields, all taken after the update.
   always_comb begin
      result_in.power_mode          = mode_in;
      result_in.mains_relay         = drive_in[pwrseq_pkg::DRV_MAINS];
      result_in.secondary_relay     = drive_in[pwrseq_pkg::DRV_SECONDARY];
      result_in.hard_mute           = drive_in[pwrseq_pkg::DRV_MUTE];
      result_in.led_power           = drive_in[pwrseq_pkg::DRV_LED_POWER];
      result_in.led_ready           = drive_in[pwrseq_pkg::DRV_LED_READY];
      result_in.shutdown_request    = drive_in[pwrseq_pkg::DRV_SHUTDOWN];
      result_in.chips_init_pulse    = p_init;
      result_in.meter_stop_pulse    = p_mstop;
      result_in.announce_pulse      = p_announce;
      result_in.save_settings_pulse = p_save;
      result_in.host_up             = host_up_in;
   end

   // State, control registers, result register and skid stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_STANDBY;
         step_ff         <= STEP_ENTRY;
         elapsed_ff      <= '0;
         drive_ff        <= pwrseq_pkg::DRV_W'(1) << pwrseq_pkg::DRV_MUTE;
         host_up_ff      <= 1'b0;
         mains_to_sec_ff <= pwrseq_pkg::RST_MAINS_TO_SECONDARY;
         rails_settle_ff <= pwrseq_pkg::RST_RAILS_SETTLE;
         unmute_delay_ff <= pwrseq_pkg::RST_UNMUTE_DELAY;
         mute_before_ff  <= pwrseq_pkg::RST_MUTE_BEFORE_SHDN;
         halt_timeout_ff <= pwrseq_pkg::RST_HALT_TIMEOUT;
         sec_to_mains_ff <= pwrseq_pkg::RST_SECONDARY_TO_MAINS;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            mode_ff    <= mode_in;
            step_ff    <= step_in;
            elapsed_ff <= elapsed_in;
            drive_ff   <= drive_in;
            host_up_ff <= host_up_in;
         end

         // Register writes; indexes past the list are dropped.
         if (csr_write) begin
            case (csr_index)
               pwrseq_pkg::CSR_MAINS_TO_SECONDARY: mains_to_sec_ff <= csr_wdata;
               pwrseq_pkg::CSR_RAILS_SETTLE:       rails_settle_ff <= csr_wdata;
               pwrseq_pkg::CSR_UNMUTE_DELAY:       unmute_delay_ff <= csr_wdata;
               pwrseq_pkg::CSR_MUTE_BEFORE_SHDN:   mute_before_ff  <= csr_wdata;
               pwrseq_pkg::CSR_HALT_TIMEOUT:       halt_timeout_ff <= csr_wdata;
               pwrseq_pkg::CSR_SECONDARY_TO_MAINS: sec_to_mains_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Output staging: the skid stage catches a result that arrives
         // while the result register is held by the consumer.
         if (skid_valid_ff) begin
            if (rsp_take) begin
               rsp_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (req_accept) begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_ff       <= result_in;
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall               = skid_valid_ff;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_power_mode          = rsp_ff.power_mode;
   assign rsp_mains_relay         = rsp_ff.mains_relay;
   assign rsp_secondary_relay     = rsp_ff.secondary_relay;
   assign rsp_hard_mute           = rsp_ff.hard_mute;
   assign rsp_led_power           = rsp_ff.led_power;
   assign rsp_led_ready           = rsp_ff.led_ready;
   assign rsp_shutdown_request    = rsp_ff.shutdown_request;
   assign rsp_chips_init_pulse    = rsp_ff.chips_init_pulse;
   assign rsp_meter_stop_pulse    = rsp_ff.meter_stop_pulse;
   assign rsp_announce_pulse      = rsp_ff.announce_pulse;
   assign rsp_save_settings_pulse = rsp_ff.save_settings_pulse;
   assign rsp_host_up             = rsp_ff.host_up;

endmodule

`default_nettype wire

// File: rtl/pwrseq_checker.sv
// Port-level checks of the power sequencer core, bound to every instance of the core.
// Depends on pwrseq_pkg and power_up_down_sequencer_core_defines.svh.
`default_nettype none
`include "power_up_down_sequencer_core_defines.svh"

module pwrseq_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [1:0]                          rsp_power_mode,
   input wire logic                                rsp_mains_relay,
   input wire logic                                rsp_secondary_relay,
   input wire logic                                rsp_hard_mute,
   input wire logic                                rsp_led_power,
   input wire logic                                rsp_led_ready,
   input wire logic                                rsp_shutdown_request,
   input wire logic                                rsp_chips_init_pulse,
   input wire logic                                rsp_meter_stop_pulse,
   input wire logic                                rsp_announce_pulse,
   input wire logic                                rsp_save_settings_pulse,
   input wire logic                                rsp_host_up
);

   logic       rsp_wait;
   logic [4:0] rsp_key;
   logic       sec_alone;
   logic       ready_muted;
   logic       standby_live;
   logic [2:0] pulse_count;

   // Observations taken from the result channel.
   assign rsp_wait     = rsp_valid && rsp_stall;
   assign rsp_key      = {rsp_valid, rsp_power_mode, rsp_mains_relay, rsp_secondary_relay};
   assign sec_alone    = rsp_secondary_relay && !rsp_mains_relay;
   assign ready_muted  = rsp_led_ready && rsp_hard_mute;
   assign standby_live = (rsp_power_mode == pwrseq_pkg::PMODE_STANDBY) &&
                         (rsp_mains_relay || rsp_shutdown_request);
   assign pulse_count  = 3'(rsp_chips_init_pulse) + 3'(rsp_meter_stop_pulse) +
                         3'(rsp_announce_pulse) + 3'(rsp_save_settings_pulse);

   // A held result stays valid and keeps its mode and relay drive.
   `PWRSEQ_ASSERT(a_hold, clock, reset, rsp_wait |=> $stable(rsp_key), "stalled result moved")

   // The secondary relay is never energized without the mains relay.
   `PWRSEQ_NEVER(a_sec_mains, clock, reset, rsp_valid && sec_alone, "secondary on without mains")

   // Fully on means unmuted; the ready led never shows with mute applied.
   `PWRSEQ_NEVER(a_ready_mute, clock, reset, rsp_valid && ready_muted, "ready led lit while muted")

   // Standby leaves the mains relay and the shutdown request released.
   `PWRSEQ_NEVER(a_standby_off, clock, reset, rsp_valid && standby_live, "power active in standby")

   // At most one action pulse per result.
   `PWRSEQ_ASSERT(a_one_pulse, clock, reset, rsp_valid |-> pulse_count <= 3'd1, "pulses overlap")

endmodule

bind power_up_down_sequencer_core pwrseq_checker u_pwrseq_checker (.*);

`default_nettype wire
